FILE: rtl/assert_macros.svh
// assertion macros shared by the line sensor modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge out of reset
`define LSCL_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("line sensor assertion failed");

// checked on every edge, reset included
`define LSCL_ASSERT_NORST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("line sensor assertion failed");

`endif

FILE: rtl/lscl_pkg.sv
// constants, types and helpers of the line sensor calibrate and locate unit
package lscl_pkg;

    localparam int SENSOR_COUNT = 6;
    localparam int SAMPLE_BITS  = 10;

    localparam int CMD_BITS   = 2;
    localparam int IDX_BITS   = 3;
    localparam int LEVEL_BITS = 10;
    localparam int LSUM_BITS  = 13;
    localparam int WSUM_BITS  = 24;
    localparam int POS_BITS   = 14;

    localparam int LEVEL_FULL  = 1000;
    localparam int WEIGHT_STEP = 1000;
    localparam int POS_MAX     = 8191;

    localparam int WEIGHT_BITS = $clog2(((2 ** IDX_BITS) - 1) * WEIGHT_STEP + 1);
    localparam int MUL_A_BITS  = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;
    localparam int MUL_B_BITS  = WEIGHT_BITS;
    localparam int PROD_BITS   = MUL_A_BITS + MUL_B_BITS;
    localparam int DIV_BITS    = (PROD_BITS > WSUM_BITS) ? PROD_BITS : WSUM_BITS;
    localparam int CNT_BITS    = $clog2(DIV_BITS + 1);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_CALIB   = 2'd1,
        CMD_MEASURE = 2'd2
    } cmd_t;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] num;
        logic [DIV_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [DIV_BITS-1:0] quot;
    } div_rsp_t;

    function automatic logic [WEIGHT_BITS-1:0] weight_of(input logic [IDX_BITS-1:0] idx);
        return WEIGHT_BITS'(int'(idx) * WEIGHT_STEP);
    endfunction

endpackage

FILE: rtl/lscl_divider.sv
// restoring divider, one quotient bit per cycle, shared by level and position
`include "assert_macros.svh"

module lscl_divider (
    input  logic                aclk,
    input  logic                aresetn,
    input  lscl_pkg::div_req_t  req,
    output lscl_pkg::div_rsp_t  rsp
);

    localparam int N = lscl_pkg::DIV_BITS;

    logic                          busy_reg;
    logic                          done_reg;
    logic [lscl_pkg::CNT_BITS-1:0] cnt_reg;
    logic [N-1:0]                  quot_reg;
    logic [N-1:0]                  rem_reg;
    logic [N-1:0]                  den_reg;

    logic [N:0] rem_shift;
    logic       ge;
    logic [N:0] rem_next;

    always_comb begin
        rem_shift = {rem_reg, quot_reg[N-1]};
        ge        = rem_shift >= {1'b0, den_reg};
        rem_next  = ge ? (rem_shift - {1'b0, den_reg}) : rem_shift;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= lscl_pkg::CNT_BITS'(N);
                quot_reg <= req.num;
                rem_reg  <= '0;
                den_reg  <= req.den;
            end else if (busy_reg) begin
                quot_reg <= {quot_reg[N-2:0], ge};
                rem_reg  <= rem_next[N-1:0];
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == lscl_pkg::CNT_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    `LSCL_ASSERT(a_no_start_while_busy, req.start |-> !busy_reg)
    `LSCL_ASSERT(a_done_ends_busy, done_reg |-> $past(busy_reg) && !busy_reg)
    `LSCL_ASSERT_NORST(a_reset_quiet, !aresetn |=> !busy_reg && !done_reg)

endmodule

FILE: rtl/line_sensor_calibrate_and_locate_unit.sv
// top level of the line sensor calibrate and locate unit: sequencer, calibration and sums
//
// A clear or calibrate transaction is absorbed in the cycle it is accepted and gives no
// result. For a measure transaction one shared multiplier scales the reading, the
// bit-serial divider normalizes it, the multiplier weights it and the sums update.
// A reading that cannot be normalized (sensor out of range, empty or zero-width
// calibration or below the minimum) skips the division. On the last sample of a scan
// a second pass through the same divider forms the position; with an empty level sum
// the position is -1 and the second pass is skipped. s_ready is high only while the
// sequencer idles; a finished result sits in the output register until taken.
`include "assert_macros.svh"

module line_sensor_calibrate_and_locate_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [lscl_pkg::CMD_BITS-1:0]       s_command,
    input  logic [lscl_pkg::IDX_BITS-1:0]       s_sensor_index,
    input  logic [lscl_pkg::SAMPLE_BITS-1:0]    s_sample,
    input  logic                                s_scan_end,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [lscl_pkg::IDX_BITS-1:0]       m_sensor_index_res,
    output logic [lscl_pkg::LEVEL_BITS-1:0]     m_normalized_level,
    output logic signed [lscl_pkg::POS_BITS-1:0] m_line_position,
    output logic                                m_position_valid
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_NORM,
        ST_NORM_GO,
        ST_DIV_NORM,
        ST_MUL_W,
        ST_ACC,
        ST_POS_GO,
        ST_DIV_POS,
        ST_OUT
    } state_t;

    localparam int SB = lscl_pkg::SAMPLE_BITS;

    state_t state_reg;

    logic [SB-1:0] cal_low_reg  [lscl_pkg::SENSOR_COUNT];
    logic [SB-1:0] cal_high_reg [lscl_pkg::SENSOR_COUNT];

    logic [lscl_pkg::WSUM_BITS-1:0]  wsum_reg;
    logic [lscl_pkg::LSUM_BITS-1:0]  lsum_reg;
    logic [lscl_pkg::IDX_BITS-1:0]   idx_reg;
    logic                            last_reg;
    logic [SB-1:0]                   diff_reg;
    logic [SB-1:0]                   den_reg;
    logic [lscl_pkg::LEVEL_BITS-1:0] level_reg;
    logic [lscl_pkg::POS_BITS-1:0]   pos_reg;
    logic [lscl_pkg::PROD_BITS-1:0]  prod_reg;

    logic                                m_valid_reg;
    logic [lscl_pkg::IDX_BITS-1:0]       m_idx_reg;
    logic [lscl_pkg::LEVEL_BITS-1:0]     m_level_reg;
    logic [lscl_pkg::POS_BITS-1:0]       m_pos_reg;
    logic                                m_posv_reg;

    lscl_pkg::div_req_t div_req;
    lscl_pkg::div_rsp_t div_rsp;

    logic                             accept;
    logic                             in_range;
    logic [SB-1:0]                    lo;
    logic [SB-1:0]                    hi;
    logic [lscl_pkg::MUL_A_BITS-1:0]  mul_a;
    logic [lscl_pkg::MUL_B_BITS-1:0]  mul_b;
    logic [lscl_pkg::WSUM_BITS:0]     wsum_add;
    logic [lscl_pkg::LSUM_BITS:0]     lsum_add;
    logic [lscl_pkg::WSUM_BITS-1:0]   wsum_new;
    logic [lscl_pkg::LSUM_BITS-1:0]   lsum_new;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        in_range = int'(s_sensor_index) < lscl_pkg::SENSOR_COUNT;
        lo       = in_range ? cal_low_reg[s_sensor_index]  : '1;
        hi       = in_range ? cal_high_reg[s_sensor_index] : '0;
    end

    always_comb begin
        if (state_reg == ST_MUL_NORM) begin
            mul_a = lscl_pkg::MUL_A_BITS'(diff_reg);
            mul_b = lscl_pkg::MUL_B_BITS'(lscl_pkg::LEVEL_FULL);
        end else begin
            mul_a = lscl_pkg::MUL_A_BITS'(level_reg);
            mul_b = lscl_pkg::weight_of(idx_reg);
        end
    end

    always_comb begin
        wsum_add = {1'b0, wsum_reg} + (lscl_pkg::WSUM_BITS + 1)'(prod_reg);
        lsum_add = {1'b0, lsum_reg}
                 + (lscl_pkg::LSUM_BITS + 1)'(level_reg);
        wsum_new = wsum_add[lscl_pkg::WSUM_BITS] ? '1 : wsum_add[lscl_pkg::WSUM_BITS-1:0];
        lsum_new = lsum_add[lscl_pkg::LSUM_BITS] ? '1 : lsum_add[lscl_pkg::LSUM_BITS-1:0];
    end

    always_comb begin
        div_req.start = (state_reg == ST_NORM_GO) || (state_reg == ST_POS_GO);
        if (state_reg == ST_POS_GO) begin
            div_req.num = lscl_pkg::DIV_BITS'(wsum_reg);
            div_req.den = lscl_pkg::DIV_BITS'(lsum_reg);
        end else begin
            div_req.num = lscl_pkg::DIV_BITS'(prod_reg);
            div_req.den = lscl_pkg::DIV_BITS'(den_reg);
        end
    end

    lscl_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            wsum_reg    <= '0;
            lsum_reg    <= '0;
            for (int k = 0; k < lscl_pkg::SENSOR_COUNT; k++) begin
                cal_low_reg[k]  <= '1;
                cal_high_reg[k] <= '0;
            end
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (lscl_pkg::cmd_t'(s_command))
                            lscl_pkg::CMD_CLEAR: begin
                                for (int k = 0; k < lscl_pkg::SENSOR_COUNT; k++) begin
                                    cal_low_reg[k]  <= '1;
                                    cal_high_reg[k] <= '0;
                                end
                            end
                            lscl_pkg::CMD_CALIB: begin
                                if (in_range) begin
                                    if (s_sample < lo) begin
                                        cal_low_reg[s_sensor_index] <= s_sample;
                                    end
                                    if (s_sample > hi) begin
                                        cal_high_reg[s_sensor_index] <= s_sample;
                                    end
                                end
                            end
                            lscl_pkg::CMD_MEASURE: begin
                                idx_reg   <= s_sensor_index;
                                last_reg  <= s_scan_end;
                                level_reg <= '0;
                                pos_reg   <= '0;
                                diff_reg  <= s_sample - lo;
                                den_reg   <= hi - lo;
                                if (in_range && (hi > lo) && (s_sample >= lo)) begin
                                    state_reg <= ST_MUL_NORM;
                                end else begin
                                    state_reg <= ST_MUL_W;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_MUL_NORM: begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= ST_NORM_GO;
                end
                ST_NORM_GO: begin
                    state_reg <= ST_DIV_NORM;
                end
                ST_DIV_NORM: begin
                    if (div_rsp.done) begin
                        if (div_rsp.quot > lscl_pkg::DIV_BITS'(lscl_pkg::LEVEL_FULL)) begin
                            level_reg <= lscl_pkg::LEVEL_BITS'(lscl_pkg::LEVEL_FULL);
                        end else begin
                            level_reg <= div_rsp.quot[lscl_pkg::LEVEL_BITS-1:0];
                        end
                        state_reg <= ST_MUL_W;
                    end
                end
                ST_MUL_W: begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    if (!last_reg) begin
                        wsum_reg  <= wsum_new;
                        lsum_reg  <= lsum_new;
                        state_reg <= ST_OUT;
                    end else if (lsum_new == '0) begin
                        wsum_reg  <= '0;
                        lsum_reg  <= '0;
                        pos_reg   <= '1;
                        state_reg <= ST_OUT;
                    end else begin
                        wsum_reg  <= wsum_new;
                        lsum_reg  <= lsum_new;
                        state_reg <= ST_POS_GO;
                    end
                end
                ST_POS_GO: begin
                    wsum_reg  <= '0;
                    lsum_reg  <= '0;
                    state_reg <= ST_DIV_POS;
                end
                ST_DIV_POS: begin
                    if (div_rsp.done) begin
                        if (div_rsp.quot > lscl_pkg::DIV_BITS'(lscl_pkg::POS_MAX)) begin
                            pos_reg <= lscl_pkg::POS_BITS'(lscl_pkg::POS_MAX);
                        end else begin
                            pos_reg <= div_rsp.quot[lscl_pkg::POS_BITS-1:0];
                        end
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_idx_reg   <= idx_reg;
                        m_level_reg <= level_reg;
                        m_pos_reg   <= pos_reg;
                        m_posv_reg  <= last_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_sensor_index_res = m_idx_reg;
    assign m_normalized_level = m_level_reg;
    assign m_line_position    = m_pos_reg;
    assign m_position_valid   = m_posv_reg;

    `LSCL_ASSERT(a_level_in_range,
        m_valid |-> m_normalized_level <= lscl_pkg::LEVEL_BITS'(lscl_pkg::LEVEL_FULL))
    `LSCL_ASSERT(a_no_position_mid_scan,
        m_valid && !m_position_valid |-> m_line_position == '0)
    `LSCL_ASSERT(a_ready_divider_idle, s_ready |-> !div_rsp.busy)

endmodule

FILE: test/line_sensor_calibrate_and_locate_unit_test.sv
// self-checking testbench of the line sensor calibrate and locate unit
module line_sensor_calibrate_and_locate_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [lscl_pkg::CMD_BITS-1:0] CMD_IGNORED = 2'd3;
    localparam int unsigned SAMPLE_FULL = (2 ** lscl_pkg::SAMPLE_BITS) - 1;
    localparam int unsigned WSUM_LIMIT = (2 ** lscl_pkg::WSUM_BITS) - 1;
    localparam int unsigned LSUM_LIMIT = (2 ** lscl_pkg::LSUM_BITS) - 1;
    localparam int RANDOM_TARGET = 2000;
    localparam longint TIMEOUT_NS = 18_000_000;

    typedef struct packed {
        logic [lscl_pkg::IDX_BITS-1:0]   idx;
        logic [lscl_pkg::LEVEL_BITS-1:0] level;
        logic [lscl_pkg::POS_BITS-1:0]   pos;
        logic                            pos_valid;
    } sensor_reading_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_HALF,
        READY_SPARSE,
        READY_PERIODIC
    } ready_pattern_t;

    logic                                  aclk;
    logic                                  aresetn;
    logic                                  s_valid;
    logic                                  s_ready;
    logic [lscl_pkg::CMD_BITS-1:0]         s_command;
    logic [lscl_pkg::IDX_BITS-1:0]         s_sensor_index;
    logic [lscl_pkg::SAMPLE_BITS-1:0]      s_sample;
    logic                                  s_scan_end;
    logic                                  m_valid;
    logic                                  m_ready;
    logic [lscl_pkg::IDX_BITS-1:0]         m_sensor_index_res;
    logic [lscl_pkg::LEVEL_BITS-1:0]       m_normalized_level;
    logic signed [lscl_pkg::POS_BITS-1:0]  m_line_position;
    logic                                  m_position_valid;

    logic [lscl_pkg::SAMPLE_BITS-1:0] sensor_min [lscl_pkg::SENSOR_COUNT];
    logic [lscl_pkg::SAMPLE_BITS-1:0] sensor_max [lscl_pkg::SENSOR_COUNT];
    int unsigned                      position_acc;
    int unsigned                      level_acc;

    sensor_reading_t pending_readings [$];
    sensor_reading_t want_reading;

    int error_count;
    int accepted_samples;
    int burst_left;
    int hold_off_request;

    line_sensor_calibrate_and_locate_unit u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_sensor_index     (s_sensor_index),
        .s_sample           (s_sample),
        .s_scan_end         (s_scan_end),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_sensor_index_res (m_sensor_index_res),
        .m_normalized_level (m_normalized_level),
        .m_line_position    (m_line_position),
        .m_position_valid   (m_position_valid)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void clear_sensor_limits();
        for (int k = 0; k < lscl_pkg::SENSOR_COUNT; k++) begin
            sensor_min[k] = lscl_pkg::SAMPLE_BITS'(SAMPLE_FULL);
            sensor_max[k] = '0;
        end
    endfunction

    // expected effect of one accepted transaction
    function automatic void locate_expected(input logic [lscl_pkg::CMD_BITS-1:0] cmd,
                                            input logic [lscl_pkg::IDX_BITS-1:0] idx,
                                            input logic [lscl_pkg::SAMPLE_BITS-1:0] smp,
                                            input logic last);
        int unsigned lvl;
        int unsigned w;
        int unsigned q;
        sensor_reading_t r;
        if (cmd == lscl_pkg::CMD_CLEAR) begin
            clear_sensor_limits();
        end else if (cmd == lscl_pkg::CMD_CALIB) begin
            if (idx < lscl_pkg::SENSOR_COUNT) begin
                if (smp < sensor_min[idx]) sensor_min[idx] = smp;
                if (smp > sensor_max[idx]) sensor_max[idx] = smp;
            end
        end else if (cmd == lscl_pkg::CMD_MEASURE) begin
            lvl = 0;
            if (idx < lscl_pkg::SENSOR_COUNT) begin
                if (sensor_max[idx] > sensor_min[idx] && smp >= sensor_min[idx]) begin
                    lvl = ((int'(smp) - int'(sensor_min[idx])) * lscl_pkg::LEVEL_FULL)
                          / (int'(sensor_max[idx]) - int'(sensor_min[idx]));
                    if (lvl > lscl_pkg::LEVEL_FULL) lvl = lscl_pkg::LEVEL_FULL;
                end
                w = lvl * int'(idx) * lscl_pkg::WEIGHT_STEP;
                position_acc = (WSUM_LIMIT - position_acc < w) ? WSUM_LIMIT
                                                               : position_acc + w;
                level_acc = (LSUM_LIMIT - level_acc < lvl) ? LSUM_LIMIT : level_acc + lvl;
            end
            r.pos = '0;
            if (last) begin
                if (level_acc == 0) begin
                    r.pos = '1;
                end else begin
                    q = position_acc / level_acc;
                    r.pos = (q > lscl_pkg::POS_MAX) ? lscl_pkg::POS_BITS'(lscl_pkg::POS_MAX)
                                                    : lscl_pkg::POS_BITS'(q);
                end
                position_acc = 0;
                level_acc = 0;
            end
            r.idx = idx;
            r.level = lscl_pkg::LEVEL_BITS'(lvl);
            r.pos_valid = last;
            pending_readings.push_back(r);
        end
    endfunction

    task automatic send_sample(input logic [lscl_pkg::CMD_BITS-1:0] cmd,
                               input logic [lscl_pkg::IDX_BITS-1:0] idx,
                               input logic [lscl_pkg::SAMPLE_BITS-1:0] smp,
                               input logic last);
        int gap;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_command <= cmd;
        s_sensor_index <= idx;
        s_sample <= smp;
        s_scan_end <= last;
        do @(posedge aclk); while (!s_ready);
        locate_expected(cmd, idx, smp, last);
        if (cmd != CMD_IGNORED) accepted_samples++;
        burst_left--;
        if (burst_left <= 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 4);
            repeat (gap) @(negedge aclk);
            burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 30);
        end
    endtask

    // receiver stall pattern, with an optional long hold-off
    initial begin
        int hold_left;
        int pattern_left;
        ready_pattern_t pattern;
        hold_left = 0;
        pattern_left = 0;
        pattern = READY_ALWAYS;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_request > 0) begin
                hold_left = hold_off_request;
                hold_off_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    pattern = ready_pattern_t'($urandom_range(0, 3));
                    pattern_left = $urandom_range(20, 300);
                end
                pattern_left--;
                case (pattern)
                    READY_ALWAYS:   m_ready <= 1'b1;
                    READY_HALF:     m_ready <= 1'($urandom_range(0, 1));
                    READY_SPARSE:   m_ready <= ($urandom_range(0, 3) == 0);
                    READY_PERIODIC: m_ready <= ((pattern_left % 13) < 4);
                    default:        m_ready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_readings.size() == 0) begin
                error_count++;
                $display("%0t: unexpected transaction, expected none, actual idx %0d",
                         $time, m_sensor_index_res);
            end else begin
                want_reading = pending_readings.pop_front();
                if (m_sensor_index_res !== want_reading.idx) begin
                    error_count++;
                    $display("%0t: sensor index mismatch, expected %0d actual %0d",
                             $time, want_reading.idx, m_sensor_index_res);
                end
                if (m_normalized_level !== want_reading.level) begin
                    error_count++;
                    $display("%0t: level mismatch, expected %0d actual %0d",
                             $time, want_reading.level, m_normalized_level);
                end
                if (m_line_position !== want_reading.pos) begin
                    error_count++;
                    $display("%0t: position mismatch, expected %0d actual %0d",
                             $time, $signed(want_reading.pos), m_line_position);
                end
                if (m_position_valid !== want_reading.pos_valid) begin
                    error_count++;
                    $display("%0t: position flag mismatch, expected %0d actual %0d",
                             $time, want_reading.pos_valid, m_position_valid);
                end
            end
        end
    end

    task automatic test_power_on_state();
        send_sample(lscl_pkg::CMD_MEASURE, 3'd0, 10'd512, 1'b1);
    endtask

    task automatic test_calibration_edges();
        send_sample(lscl_pkg::CMD_CALIB, 3'd0, 10'd0, 1'b0);
        send_sample(lscl_pkg::CMD_CALIB, 3'd0, 10'd1023, 1'b0);
        send_sample(lscl_pkg::CMD_CALIB, 3'd5, 10'd100, 1'b0);
        send_sample(lscl_pkg::CMD_CALIB, 3'd5, 10'd900, 1'b0);
        send_sample(lscl_pkg::CMD_CALIB, 3'd6, 10'd512, 1'b0);
        send_sample(lscl_pkg::CMD_CALIB, 3'd7, 10'd1023, 1'b1);
        send_sample(lscl_pkg::CMD_MEASURE, 3'd0, 10'd1023, 1'b0);
        send_sample(lscl_pkg::CMD_MEASURE, 3'd5, 10'd100, 1'b0);
        send_sample(lscl_pkg::CMD_MEASURE, 3'd5, 10'd50, 1'b0);
        send_sample(lscl_pkg::CMD_MEASURE, 3'd5, 10'd1023, 1'b0);
        send_sample(lscl_pkg::CMD_MEASURE, 3'd7, 10'd0, 1'b1);
    endtask

    task automatic test_ignored_command();
        send_sample(CMD_IGNORED, 3'd7, 10'd1023, 1'b1);
        send_sample(lscl_pkg::CMD_MEASURE, 3'd6, 10'd1023, 1'b1);
    endtask

    task automatic test_degenerate_range();
        send_sample(lscl_pkg::CMD_CALIB, 3'd3, 10'd400, 1'b0);
        send_sample(lscl_pkg::CMD_MEASURE, 3'd3, 10'd400, 1'b1);
    endtask

    task automatic test_clear_calibration();
        send_sample(lscl_pkg::CMD_CLEAR, 3'd2, 10'd777, 1'b1);
        send_sample(lscl_pkg::CMD_MEASURE, 3'd0, 10'd1023, 1'b1);
    endtask

    task automatic test_sum_saturation();
        send_sample(lscl_pkg::CMD_CALIB, 3'd5, 10'd0, 1'b0);
        send_sample(lscl_pkg::CMD_CALIB, 3'd5, 10'd1023, 1'b0);
        repeat (9) send_sample(lscl_pkg::CMD_MEASURE, 3'd5, 10'd1023, 1'b0);
        send_sample(lscl_pkg::CMD_MEASURE, 3'd5, 10'd1023, 1'b1);
    endtask

    // output held off long enough for the unit to stop taking input
    task automatic test_input_backpressure();
        burst_left = 100;
        hold_off_request = 400;
        for (int k = 0; k < 2 * lscl_pkg::SENSOR_COUNT; k++)
            send_sample(lscl_pkg::CMD_MEASURE,
                        lscl_pkg::IDX_BITS'(k % lscl_pkg::SENSOR_COUNT),
                        lscl_pkg::SAMPLE_BITS'($urandom),
                        (k % lscl_pkg::SENSOR_COUNT) == lscl_pkg::SENSOR_COUNT - 1);
    endtask

    task automatic test_random_scans();
        int sens_lo [lscl_pkg::SENSOR_COUNT];
        int sens_hi [lscl_pkg::SENSOR_COUNT];
        int pick;
        int passes;
        int v;
        for (int k = 0; k < lscl_pkg::SENSOR_COUNT; k++) begin
            sens_lo[k] = 0;
            sens_hi[k] = SAMPLE_FULL;
        end
        while (accepted_samples < RANDOM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                send_sample(lscl_pkg::CMD_CLEAR, lscl_pkg::IDX_BITS'($urandom),
                            lscl_pkg::SAMPLE_BITS'($urandom), 1'($urandom));
                for (int k = 0; k < lscl_pkg::SENSOR_COUNT; k++) begin
                    sens_lo[k] = $urandom_range(0, 700);
                    sens_hi[k] = sens_lo[k] + $urandom_range(0, SAMPLE_FULL - sens_lo[k]);
                end
                passes = $urandom_range(1, 4);
                for (int p = 0; p < passes; p++)
                    for (int k = 0; k < lscl_pkg::SENSOR_COUNT; k++)
                        if ($urandom_range(0, 7) != 0)
                            send_sample(lscl_pkg::CMD_CALIB, lscl_pkg::IDX_BITS'(k),
                                        lscl_pkg::SAMPLE_BITS'(
                                            $urandom_range(sens_lo[k], sens_hi[k])),
                                        1'($urandom));
            end else if (pick < 82) begin
                for (int k = 0; k < lscl_pkg::SENSOR_COUNT; k++) begin
                    case ($urandom_range(0, 9))
                        0:       v = 0;
                        1:       v = SAMPLE_FULL;
                        2, 3:    v = $urandom_range(0, SAMPLE_FULL);
                        default: v = $urandom_range(sens_lo[k], sens_hi[k] + 60) - 30;
                    endcase
                    if (v < 0) v = 0;
                    if (v > SAMPLE_FULL) v = SAMPLE_FULL;
                    send_sample(lscl_pkg::CMD_MEASURE, lscl_pkg::IDX_BITS'(k),
                                lscl_pkg::SAMPLE_BITS'(v),
                                k == lscl_pkg::SENSOR_COUNT - 1);
                end
            end else begin
                send_sample(lscl_pkg::CMD_BITS'($urandom_range(0, 3)),
                            lscl_pkg::IDX_BITS'($urandom),
                            lscl_pkg::SAMPLE_BITS'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        clear_sensor_limits();
        position_acc = 0;
        level_acc = 0;
        error_count = 0;
        accepted_samples = 0;
        burst_left = 0;
        hold_off_request = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_command = lscl_pkg::CMD_CLEAR;
        s_sensor_index = '0;
        s_sample = '0;
        s_scan_end = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_power_on_state();
        test_calibration_edges();
        test_ignored_command();
        test_degenerate_range();
        test_clear_calibration();
        test_sum_saturation();
        test_input_backpressure();
        test_random_scans();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/lscl_pkg.sv
rtl/lscl_divider.sv
rtl/line_sensor_calibrate_and_locate_unit.sv
test/line_sensor_calibrate_and_locate_unit_test.sv
